FILE: rtl/lru_key_value_cache_assert.svh
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

// Concurrent property check, sampled on the rising clock, off while in reset.
`define LKV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define LKV_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LKV_ASSERT(lbl, clk, rst_n, prop, msg)
`define LKV_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [0:0] {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_e;

    typedef struct packed {
        cmd_e                     command;
        logic signed [KEY_W-1:0]  lookup_key;
        logic signed [VAL_W-1:0]  write_value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [VAL_W-1:0]  read_value;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/lkv_find.sv
`default_nettype none

// Lowest-index priority encoder over one request bit per entry.
module lkv_find (
    input  wire logic [lkv_pkg::ENTRIES-1:0]  req,
    output logic                              found,
    output logic [lkv_pkg::IDX_W-1:0]         idx
);

    always_comb
    begin
        found = |req;
        idx   = '0;
        for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (req[i])
            begin
                idx = lkv_pkg::IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lkv_store.sv
`default_nettype none

// Entry storage, parallel key match, recency ranks and replacement.
module lkv_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        update,
    input  wire lkv_pkg::req_t               req,
    input  wire logic [lkv_pkg::CAP_W-1:0]   capacity,
    output lkv_pkg::rsp_t                    rsp
);

    localparam int N = lkv_pkg::ENTRIES;

    logic                               valid_reg [N];
    logic                               valid_next [N];
    logic [lkv_pkg::IDX_W-1:0]          rank_reg [N];
    logic [lkv_pkg::IDX_W-1:0]          rank_next [N];
    logic [lkv_pkg::KEY_W-1:0]          key_reg [N];
    logic [lkv_pkg::VAL_W-1:0]          value_reg [N];
    logic [lkv_pkg::CNT_W-1:0]          occ_reg;
    logic [lkv_pkg::CNT_W-1:0]          occ_next;

    logic [N-1:0]                       hit_vec;
    logic [N-1:0]                       victim_vec;
    logic [N-1:0]                       free_vec;
    logic                               hit;
    logic                               victim_found;
    logic                               free_found;
    logic [lkv_pkg::IDX_W-1:0]          hit_idx;
    logic [lkv_pkg::IDX_W-1:0]          victim_idx;
    logic [lkv_pkg::IDX_W-1:0]          free_idx;

    logic [lkv_pkg::CMP_W-1:0]          cap_ext;
    logic [lkv_pkg::CMP_W-1:0]          eff_cap;
    logic                               full;
    logic [lkv_pkg::IDX_W-1:0]          lru_rank;

    logic                               touch;
    logic [lkv_pkg::IDX_W-1:0]          slot;
    logic [lkv_pkg::IDX_W-1:0]          old_rank;
    logic                               insert;
    logic                               write_key;
    logic                               write_value;

    assign lru_rank = lkv_pkg::IDX_W'(occ_reg - lkv_pkg::CNT_W'(1));

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            hit_vec[i]    = valid_reg[i] && (key_reg[i] == req.lookup_key);
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            free_vec[i]   = !valid_reg[i];
        end
    end

    lkv_find u_find_hit (
        .req   (hit_vec),
        .found (hit),
        .idx   (hit_idx)
    );

    lkv_find u_find_victim (
        .req   (victim_vec),
        .found (victim_found),
        .idx   (victim_idx)
    );

    lkv_find u_find_free (
        .req   (free_vec),
        .found (free_found),
        .idx   (free_idx)
    );

    // Zero acts as one, anything above the entry count saturates.
    always_comb
    begin
        cap_ext = lkv_pkg::CMP_W'(capacity);
        priority if (cap_ext == '0)
        begin
            eff_cap = lkv_pkg::CMP_W'(1);
        end
        else if (cap_ext > lkv_pkg::CMP_W'(N))
        begin
            eff_cap = lkv_pkg::CMP_W'(N);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        full = (lkv_pkg::CMP_W'(occ_reg) >= eff_cap) && (occ_reg != '0);
    end

    always_comb
    begin
        touch       = 1'b0;
        slot        = hit_idx;
        old_rank    = rank_reg[hit_idx];
        insert      = 1'b0;
        write_key   = 1'b0;
        write_value = 1'b0;
        rsp.hit        = hit;
        rsp.read_value = '0;
        unique case (req.command)
            lkv_pkg::CMD_GET:
            begin
                if (hit)
                begin
                    touch          = 1'b1;
                    rsp.read_value = value_reg[hit_idx];
                end
            end
            lkv_pkg::CMD_PUT:
            begin
                touch       = 1'b1;
                write_value = 1'b1;
                if (!hit)
                begin
                    write_key = 1'b1;
                    if (full)
                    begin
                        // reuse the least recent slot; index 0 if none matched
                        slot     = victim_found ? victim_idx : '0;
                        old_rank = lru_rank;
                    end
                    else
                    begin
                        slot     = free_idx;
                        old_rank = lkv_pkg::IDX_W'(occ_reg);
                        insert   = free_found;
                    end
                end
            end
            default:
            begin
                touch = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        occ_next = occ_reg;
        for (int i = 0; i < N; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
        end
        if (update && touch)
        begin
            // age every valid entry more recent than the touched one
            for (int i = 0; i < N; i++)
            begin
                if (valid_reg[i] && (lkv_pkg::IDX_W'(i) != slot) && (rank_reg[i] < old_rank))
                begin
                    rank_next[i] = rank_reg[i] + lkv_pkg::IDX_W'(1);
                end
            end
            rank_next[slot] = '0;
            if (insert)
            begin
                valid_next[slot] = 1'b1;
                occ_next         = occ_reg + lkv_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            occ_reg <= occ_next;
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= valid_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (update && write_key)
        begin
            key_reg[slot] <= req.lookup_key;
        end
        if (update && write_value)
        begin
            value_reg[slot] <= req.write_value;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache.sv
// LRU key-value cache, fully associative, 16 entries.
//
// Request channel (req_valid/req_ready/req): one get or put per transaction.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one response per request,
// in request order. hit reports whether the key was present; read_value holds
// the stored value on a get hit and zero otherwise.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes capacity; always ready.
// Write it only while no request is in flight.
//
// Path: an accepted request is held in the request register, then looked up
// and applied to the store as it moves into the response register (rsp_valid).
// Throughput: one request per cycle while the response is not stalled; the key
// match, rank update and replacement all complete combinationally between the
// request register and the response register.
// Stall: while rsp_ready is low the response holds, the request register
// keeps its item, and req_ready drops once that register is occupied.
// Reset: the store is empty, all ranks zero, capacity 16.
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire lkv_pkg::req_t               req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output lkv_pkg::rsp_t                    rsp,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_data
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    lkv_pkg::req_t               in_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    lkv_pkg::rsp_t               out_reg;
    logic [lkv_pkg::CAP_W-1:0]   cap_reg;
    logic [lkv_pkg::CAP_W-1:0]   cap_next;

    logic                        advance;
    logic                        req_fire;
    lkv_pkg::rsp_t               rsp_comb;

    // advance the held request into the response register when it is empty or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    lkv_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (advance),
        .req      (in_reg),
        .capacity (cap_reg),
        .rsp      (rsp_comb)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        cap_next       = cap_reg;
        if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (req_fire)
        begin
            in_valid_next = 1'b1;
        end
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= lkv_pkg::CAP_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cap_reg       <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            in_reg <= req;
        end
        if (advance)
        begin
            out_reg <= rsp_comb;
        end
    end

    `LKV_ASSERT_NEVER(a_no_overwrite, clk, rst_n, req_fire && in_valid_reg && !advance, "request register overwritten")
    `LKV_ASSERT(a_advance_gives_rsp, clk, rst_n, advance |=> out_valid_reg, "advanced request produced no response")
    `LKV_ASSERT(a_stall_blocks_advance, clk, rst_n, (out_valid_reg && !rsp_ready) |-> !advance, "request advanced over a stalled response")

endmodule

`default_nettype wire
